// ===== sv/rdcd_pkg.sv =====
// ----------------------------------------------------------------------------
// rdcd_pkg
// shared types and constants of the remote drive command decoder
// ----------------------------------------------------------------------------
package rdcd_pkg;

  localparam int unsigned ENTRY_SLOTS_DEF = 5;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TRIM  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TURN_BOOST = CFG_IDX_W'(1);

  localparam logic [CFG_DAT_W-1:0] LEFT_TRIM_RST  = CFG_DAT_W'(2);
  localparam logic [CFG_DAT_W-1:0] TURN_BOOST_RST = CFG_DAT_W'(7);

  localparam logic [6:0] SPEED_MAX = 7'd127;
  localparam logic [6:0] SPEED_RST = 7'd51;

  localparam logic [7:0] CH_REMOTE = 8'h41;  // A
  localparam logic [7:0] CH_AUTO   = 8'h42;  // B
  localparam logic [7:0] CH_FWD    = 8'h46;  // F
  localparam logic [7:0] CH_BACK   = 8'h54;  // T
  localparam logic [7:0] CH_RIGHT  = 8'h44;  // D
  localparam logic [7:0] CH_LEFT   = 8'h45;  // E
  localparam logic [7:0] CH_FWD_R  = 8'h43;  // C
  localparam logic [7:0] CH_FWD_L  = 8'h47;  // G
  localparam logic [7:0] CH_BACK_R = 8'h48;  // H
  localparam logic [7:0] CH_BACK_L = 8'h49;  // I
  localparam logic [7:0] CH_STOP   = 8'h53;  // S
  localparam logic [7:0] CH_ENTRY  = 8'h57;  // W
  localparam logic [7:0] CH_APPLY  = 8'h59;  // Y
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    DIR_STOP   = 4'd0,
    DIR_FWD    = 4'd1,
    DIR_BACK   = 4'd2,
    DIR_RIGHT  = 4'd3,
    DIR_LEFT   = 4'd4,
    DIR_FWD_R  = 4'd5,
    DIR_FWD_L  = 4'd6,
    DIR_BACK_R = 4'd7,
    DIR_BACK_L = 4'd8
  } dir_e;

endpackage

// ===== sv/remote_drive_command_decoder_core.sv =====
// ----------------------------------------------------------------------------
// remote_drive_command_decoder_core
// decodes remote link bytes into drive mode, direction, speed and motor pins
// ----------------------------------------------------------------------------
// an accepted byte's result item appears in the next cycle
// throughput: one item per cycle while out_ready_i is high, set by the
// single result register stage; it frees itself in the same cycle it is taken
// reset: automatic mode, stop, speed 51, no open speed entry, trim 2, boost 7
// ----------------------------------------------------------------------------
module remote_drive_command_decoder_core
  import rdcd_pkg::*;
#(
  parameter int unsigned ENTRY_SLOTS = ENTRY_SLOTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,

  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           rx_byte_i,

  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 remote_mode_o,
  output logic [3:0]           direction_o,
  output logic [6:0]           speed_o,
  output logic [7:0]           duty_a_o,
  output logic [7:0]           duty_b_o,
  output logic                 in1_o,
  output logic                 in2_o,
  output logic                 in3_o,
  output logic                 in4_o,
  output logic                 speed_error_o
);

  localparam int unsigned CNT_W = $clog2(ENTRY_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(ENTRY_SLOTS);

  logic [CFG_DAT_W-1:0] trim_q, boost_q;

  logic             mode_q, mode_d;
  dir_e             dir_q, dir_d;
  logic [6:0]       speed_q, speed_d;
  logic             open_q, open_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       val_q, val_d;
  logic             ended_q, ended_d;
  logic             in3_q, in3_d;

  logic             out_valid_q;
  logic             rm_q, p1_q, p2_q, p3_q, p4_q, err_q;
  logic [3:0]       dir_out_q;
  logic [6:0]       spd_out_q;
  logic [7:0]       da_q, db_q;

  logic       in_fire;
  logic       is_digit;
  logic       err_d;
  logic       p1, p2, p3, p4;
  logic [7:0] da, db, v8, trim8, boost8;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_digit    = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);

  // next state of the command decoder
  always_comb begin
    mode_d  = mode_q;
    dir_d   = dir_q;
    speed_d = speed_q;
    open_d  = open_q;
    cnt_d   = cnt_q;
    val_d   = val_q;
    ended_d = ended_q;
    err_d   = 1'b0;

    if (rx_byte_i == CH_REMOTE) begin
      mode_d = 1'b1;
    end else if (rx_byte_i == CH_AUTO) begin
      mode_d = 1'b0;
    end

    if (mode_d) begin
      unique case (rx_byte_i)
        CH_FWD:    dir_d = DIR_FWD;
        CH_BACK:   dir_d = DIR_BACK;
        CH_RIGHT:  dir_d = DIR_RIGHT;
        CH_LEFT:   dir_d = DIR_LEFT;
        CH_FWD_R:  dir_d = DIR_FWD_R;
        CH_FWD_L:  dir_d = DIR_FWD_L;
        CH_BACK_R: dir_d = DIR_BACK_R;
        CH_BACK_L: dir_d = DIR_BACK_L;
        CH_STOP:   dir_d = DIR_STOP;
        default:   dir_d = dir_q;
      endcase
    end

    if (rx_byte_i == CH_ENTRY) begin
      open_d  = 1'b1;
      cnt_d   = CNT_W'(1);
      val_d   = 8'd0;
      ended_d = 1'b0;
    end else if (rx_byte_i == CH_APPLY) begin
      open_d = 1'b0;
      if (val_q == 8'd0) begin
        err_d   = 1'b1;
        speed_d = SPEED_MAX;
      end else if (val_q[7]) begin
        speed_d = SPEED_MAX;
      end else begin
        speed_d = val_q[6:0];
      end
    end else if (open_q && (cnt_q < SLOTS)) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (!ended_q) begin
        if (is_digit) begin
          val_d = {val_q[4:0], 3'b000} + {val_q[6:0], 1'b0} + (rx_byte_i - CH_ZERO);
        end else begin
          ended_d = 1'b1;
        end
      end
    end
  end

  // pin levels and duties after this item
  assign v8     = {1'b0, speed_d};
  assign trim8  = 8'(trim_q);
  assign boost8 = 8'(boost_q);

  always_comb begin
    p1 = 1'b0;
    p2 = 1'b0;
    p3 = 1'b0;
    p4 = 1'b0;
    da = 8'd0;
    db = 8'd0;
    in3_d = in3_q;
    if (mode_d) begin
      unique case (dir_d)
        DIR_FWD: begin
          p2 = 1'b1; p4 = 1'b1; da = v8; db = v8;
        end
        DIR_BACK: begin
          p1 = 1'b1; p3 = 1'b1; da = v8; db = v8;
        end
        DIR_RIGHT: begin
          p2 = 1'b1; p3 = 1'b1; da = v8 + trim8; db = v8;
        end
        DIR_LEFT: begin
          p1 = 1'b1; p4 = 1'b1; da = v8 + trim8; db = v8;
        end
        DIR_FWD_R: begin
          p2 = 1'b1; p4 = 1'b1; da = v8 + boost8; db = v8;
        end
        DIR_FWD_L: begin
          p2 = 1'b1; p4 = 1'b1; da = v8; db = v8 + boost8;
        end
        DIR_BACK_R: begin
          p1 = 1'b1; p3 = 1'b1; da = v8 + boost8 + trim8; db = v8;
        end
        DIR_BACK_L: begin
          p1 = 1'b1; p3 = 1'b1; da = v8; db = v8 + boost8;
        end
        default: begin
          p3 = in3_q;
        end
      endcase
      in3_d = p3;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_q  <= LEFT_TRIM_RST;
      boost_q <= TURN_BOOST_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_LEFT_TRIM) begin
        trim_q <= cfg_data_i;
      end else if (cfg_index_i == REG_TURN_BOOST) begin
        boost_q <= cfg_data_i;
      end
    end
  end

  // decoder state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      dir_q       <= DIR_STOP;
      speed_q     <= SPEED_RST;
      open_q      <= 1'b0;
      cnt_q       <= '0;
      val_q       <= 8'd0;
      ended_q     <= 1'b0;
      in3_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_q  <= mode_d;
        dir_q   <= dir_d;
        speed_q <= speed_d;
        open_q  <= open_d;
        cnt_q   <= cnt_d;
        val_q   <= val_d;
        ended_q <= ended_d;
        in3_q   <= in3_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rm_q      <= mode_d;
      dir_out_q <= dir_d;
      spd_out_q <= speed_d;
      da_q      <= da;
      db_q      <= db;
      p1_q      <= p1;
      p2_q      <= p2;
      p3_q      <= p3;
      p4_q      <= p4;
      err_q     <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign remote_mode_o = rm_q;
  assign direction_o   = dir_out_q;
  assign speed_o       = spd_out_q;
  assign duty_a_o      = da_q;
  assign duty_b_o      = db_q;
  assign in1_o         = p1_q;
  assign in2_o         = p2_q;
  assign in3_o         = p3_q;
  assign in4_o         = p4_q;
  assign speed_error_o = err_q;

  a_err_speed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && speed_error_o |-> speed_o == SPEED_MAX)
    else $error("speed error without saturated speed");

  a_auto_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !remote_mode_o |->
      duty_a_o == 8'd0 && duty_b_o == 8'd0 && !in1_o && !in2_o && !in3_o && !in4_o)
    else $error("motor drive active in automatic mode");

  a_bridge_legal : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(in1_o && in2_o) && !(in3_o && in4_o))
    else $error("h-bridge shoot-through");

  a_speed_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> speed_o != 7'd0)
    else $error("zero base speed");

  a_entry_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= SLOTS)
    else $error("entry count beyond slots");

endmodule
